// ===== hdl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, round constants and initial hash value for the SHA-256 core.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned NUM_ROUNDS = 64;
    localparam int unsigned BLK_WORDS  = 16;
    localparam int unsigned HASH_WORDS = 8;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    typedef logic [31:0] word_t;

    localparam word_t ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t INIT_H [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // block buffer / message schedule control
    typedef struct packed {
        logic        wr_byte;
        logic [5:0]  pos;
        logic [7:0]  data;
        logic        pad;
        logic        clr_low;
        logic        len_wr;
        logic        shift;
        logic [63:0] len;
    } sched_ctl_t;

    // round unit control
    typedef struct packed {
        logic       load;
        logic       step;
        logic       fold;
        logic       init;
        logic       rotate;
        logic [5:0] rnd;
    } rnd_ctl_t;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== hdl/sha256_sched.sv =====
// ----------------------------------------------------------------------------
// sha256_sched
// Block buffer and message schedule window: byte packing, padding, and
// one schedule word per round.
// ----------------------------------------------------------------------------
module sha256_sched
    import sha256_pkg::*;
(
    input  logic       clk,
    input  sched_ctl_t ctl,
    output word_t      w_cur
);

    word_t w_reg  [BLK_WORDS];
    word_t w_next [BLK_WORDS];

    word_t s0;
    word_t s1;
    word_t w_new;
    logic [4:0] sh;
    logic [3:0] idx;
    logic [5:0] bpos;

    assign w_cur = w_reg[0];

    always_comb
    begin
        s0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        idx   = ctl.pos[5:2];
        sh    = {~ctl.pos[1:0], 3'b000};
        bpos  = '0;
        for (int i = 0; i < BLK_WORDS; i++)
        begin
            w_next[i] = w_reg[i];
        end
        if (ctl.shift)
        begin
            for (int i = 0; i < BLK_WORDS - 1; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[BLK_WORDS - 1] = w_new;
        end
        if (ctl.wr_byte)
        begin
            if (ctl.pos[1:0] == 2'd0)
            begin
                w_next[idx] = {ctl.data, 24'h0};
            end
            else
            begin
                w_next[idx] = w_reg[idx] | (word_t'(ctl.data) << sh);
            end
        end
        if (ctl.pad)
        begin
            for (int i = 0; i < BLK_WORDS; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    bpos = 6'(i * 4 + j);
                    if (bpos == ctl.pos)
                    begin
                        w_next[i][31 - j * 8 -: 8] = PAD_BYTE;
                    end
                    else if (bpos > ctl.pos)
                    begin
                        w_next[i][31 - j * 8 -: 8] = 8'h00;
                    end
                end
            end
        end
        if (ctl.clr_low)
        begin
            for (int i = 0; i < BLK_WORDS - 2; i++)
            begin
                w_next[i] = '0;
            end
        end
        if (ctl.len_wr)
        begin
            w_next[BLK_WORDS - 2] = ctl.len[63:32];
            w_next[BLK_WORDS - 1] = ctl.len[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BLK_WORDS; i++)
        begin
            w_reg[i] <= w_next[i];
        end
    end

endmodule

// ===== hdl/sha256_round.sv =====
// ----------------------------------------------------------------------------
// sha256_round
// Working variables a..h with one compression round per cycle while step is
// high, and the chaining value that folds each block and shifts out the digest.
// ----------------------------------------------------------------------------
module sha256_round
    import sha256_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rnd_ctl_t ctl,
    input  word_t    w_cur,
    output word_t    h_out
);

    word_t v_reg [HASH_WORDS];
    word_t h_reg [HASH_WORDS];

    word_t sum0;
    word_t sum1;
    word_t ch;
    word_t maj;
    word_t t1;
    word_t t2;

    assign h_out = h_reg[0];

    always_comb
    begin
        sum1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + sum1 + ch + ROUND_K[ctl.rnd] + w_cur;
        sum0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = sum0 + maj;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (ctl.step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                h_reg[i] <= INIT_H[i];
            end
        end
        else if (ctl.init)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                h_reg[i] <= INIT_H[i];
            end
        end
        else if (ctl.fold)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
        else if (ctl.rotate)
        begin
            for (int i = 0; i < HASH_WORDS - 1; i++)
            begin
                h_reg[i] <= h_reg[i + 1];
            end
            h_reg[HASH_WORDS - 1] <= h_reg[0];
        end
    end

endmodule

// ===== hdl/sha256_hash_engine_core.sv =====
// ----------------------------------------------------------------------------
// sha256_hash_engine_core
// Byte-stream SHA-256: packs bytes into 512-bit blocks, compresses with one
// shared round unit, pads at end of message and emits the eight digest words.
//
//   channel  | dir | tdata          | tuser       | tlast
//   s_axis   | in  | [7:0] byte     | byte_valid  | end_of_message
//   m_axis   | out | [31:0] digest  | -           | last digest word
//
// A byte that does not fill the block leaves the core ready for the next byte.
// A block is one load, 64 rounds (one per cycle in the round unit), one fold.
// End of message: the pad state is the load of the final block (two blocks,
// with the length state as the second load when fill >= 56), then eight
// digest transfers. s_axis_tready is low throughout.
// rst_n clears the sequencer, fill and length and sets the chaining value to the initial hash value at once.
// ----------------------------------------------------------------------------
module sha256_hash_engine_core
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] byte_valid
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic        m_axis_tlast    // digest_last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_COMP = 3'd1;
    localparam logic [2:0] ST_FOLD = 3'd2;
    localparam logic [2:0] ST_PAD  = 3'd3;
    localparam logic [2:0] ST_LEN  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [1:0] JOB_DATA  = 2'd0;
    localparam logic [1:0] JOB_PAD   = 2'd1;
    localparam logic [1:0] JOB_FINAL = 2'd2;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  job_reg, job_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  ocnt_reg, ocnt_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic        eom_reg, eom_next;

    logic       in_xfer;
    logic       out_xfer;
    logic [6:0] fill_inc;
    sched_ctl_t sctl;
    rnd_ctl_t   rctl;
    word_t      w_cur;
    word_t      h_out;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = h_out;
    assign m_axis_tlast  = (ocnt_reg == 3'd7);
    assign fill_inc      = {1'b0, fill_reg} + 7'd1;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        rnd_next   = rnd_reg;
        ocnt_next  = ocnt_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        eom_next   = eom_reg;

        sctl         = '0;
        sctl.pos     = fill_reg;
        sctl.data    = s_axis_tdata;
        sctl.len     = len_reg;
        rctl         = '0;
        rctl.rnd     = rnd_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (s_axis_tuser)
                    begin
                        sctl.wr_byte = 1'b1;
                        len_next     = len_reg + 64'd8;
                        fill_next    = fill_inc[5:0];
                    end
                    if (s_axis_tuser && fill_inc[6])
                    begin
                        eom_next   = s_axis_tlast;
                        job_next   = JOB_DATA;
                        rnd_next   = '0;
                        rctl.load  = 1'b1;
                        state_next = ST_COMP;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_COMP:
            begin
                rctl.step  = 1'b1;
                sctl.shift = 1'b1;
                rnd_next   = rnd_reg + 6'd1;
                if (rnd_reg == 6'(NUM_ROUNDS - 1))
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                rctl.fold = 1'b1;
                unique case (job_reg)
                    JOB_DATA:  state_next = eom_reg ? ST_PAD : ST_IDLE;
                    JOB_PAD:   state_next = ST_LEN;
                    default:
                    begin
                        ocnt_next  = '0;
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_PAD:
            begin
                eom_next   = 1'b0;
                sctl.pad   = 1'b1;
                rnd_next   = '0;
                rctl.load  = 1'b1;
                state_next = ST_COMP;
                if (fill_reg >= LEN_POS)
                begin
                    job_next = JOB_PAD;
                end
                else
                begin
                    sctl.len_wr = 1'b1;
                    job_next    = JOB_FINAL;
                end
            end
            ST_LEN:
            begin
                sctl.clr_low = 1'b1;
                sctl.len_wr  = 1'b1;
                job_next     = JOB_FINAL;
                rnd_next     = '0;
                rctl.load    = 1'b1;
                state_next   = ST_COMP;
            end
            ST_OUT:
            begin
                if (out_xfer)
                begin
                    ocnt_next = ocnt_reg + 3'd1;
                    if (ocnt_reg == 3'd7)
                    begin
                        rctl.init  = 1'b1;
                        fill_next  = '0;
                        len_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rctl.rotate = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_DATA;
            rnd_reg   <= '0;
            ocnt_reg  <= '0;
            fill_reg  <= '0;
            len_reg   <= '0;
            eom_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            rnd_reg   <= rnd_next;
            ocnt_reg  <= ocnt_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            eom_reg   <= eom_next;
        end
    end

    sha256_sched u_sched
    (
        .clk   (clk),
        .ctl   (sctl),
        .w_cur (w_cur)
    );

    sha256_round u_round
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rctl),
        .w_cur (w_cur),
        .h_out (h_out)
    );

endmodule
